### hw/rtl/bgtm_pkg.sv
// shared types, constants and helpers for the binary gradient template match block
package bgtm_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int IMAGE_WIDTH_RST = 1024;
    localparam int MIN_WIDTH       = 8;
    localparam int WIN_SIZE        = 8;
    localparam int PLANES          = 4;
    localparam int PLANE_LSB       = 4;
    localparam int WORD_W          = 64;
    localparam int CNT_W           = 7;
    localparam int SUM_W           = 11;
    localparam int COEFF_W         = 32;
    localparam int SCORE_W         = 43;
    localparam int IMG_W_BITS      = 11;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int ROWS_W          = 3;
    localparam logic [ROWS_W-1:0] ROWS_MAX = 3'd7;
    localparam int OUTQ_DEPTH      = 8;
    localparam int OUTQ_PTR_W      = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W      = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_TEMPLATE_FIRST  = 3'd1,
        REG_TEMPLATE_SECOND = 3'd2,
        REG_COEFF_FIRST     = 3'd3,
        REG_COEFF_SECOND    = 3'd4
    } bgtm_reg_t;

    typedef struct packed {
        logic full;
        logic last;
    } bgtm_flags_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               window_full;
        logic               row_end;
    } bgtm_result_t;

    typedef logic [PLANES-1:0][WORD_W-1:0] bgtm_win_t;
    typedef logic [PLANES-1:0][CNT_W-1:0]  bgtm_cnt_t;

    function automatic logic [CNT_W-1:0] count_ones64(input logic [WORD_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

### hw/rtl/bgtm_if.sv
// channel interfaces: pixel input, score output and register writes
interface bgtm_pix_if;
    import bgtm_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] magnitude;
    logic       frame_start;
    modport source (output valid, output magnitude, output frame_start, input ready);
    modport sink (input valid, input magnitude, input frame_start, output ready);
endinterface

interface bgtm_score_if;
    import bgtm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      window_full;
    logic                      row_end;
    modport source (output valid, output score, output window_full, output row_end,
                    input ready);
    modport sink (input valid, input score, input window_full, input row_end,
                  output ready);
endinterface

interface bgtm_cfg_if;
    import bgtm_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/binary_gradient_template_match.sv
// top level: binarised gradient 8x8 window scoring against two templates
//
//  channel | dir | beat carries
//  pix     | in  | magnitude, frame_start
//  res     | out | score, window_full, row_end
//  cfg     | in  | index, data (register write, always ready)
//
// one pixel per cycle while pix.ready is high, set by one column store
// read-modify-write per cycle; results pass window, score and queue regs
// the result queue holds 8 beats; pix.ready falls when 8 results are owed
// no clearing pass after reset: column entries are written before use
// the user alone must change registers only while no beat is in flight
module binary_gradient_template_match #(
    parameter int MAX_WIDTH = bgtm_pkg::MAX_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bgtm_pix_if.sink           pix,
    bgtm_cfg_if.sink           cfg,
    bgtm_score_if.source       res
);
    import bgtm_pkg::*;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CMP_W     = (COL_W + 1 > IMG_W_BITS) ? COL_W + 1 : IMG_W_BITS;
    localparam int RST_WIDTH = (IMAGE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RST;

    logic [CMP_W-1:0]          width_last_reg;
    logic [CMP_W-1:0]          width_raw, width_eff;
    logic [WORD_W-1:0]         template_first_reg, template_second_reg;
    logic signed [COEFF_W-1:0] coeff_first_reg, coeff_second_reg;

    logic                      pix_accept;
    logic                      credit_ok;
    logic                      win_valid;
    bgtm_win_t                 win;
    bgtm_flags_t               win_flags;
    logic                      score_valid;
    bgtm_result_t              score_res;
    bgtm_result_t              head;

    assign cfg.ready  = 1'b1;
    assign pix.ready  = credit_ok;
    assign pix_accept = pix.valid && credit_ok;

    // width saturated into the supported range, stored as last column index
    always_comb
    begin
        width_raw = CMP_W'(cfg.data[IMG_W_BITS-1:0]);
        if (width_raw < CMP_W'(MIN_WIDTH))
        begin
            width_eff = CMP_W'(MIN_WIDTH);
        end
        else if (width_raw > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg      <= CMP_W'(RST_WIDTH - 1);
            template_first_reg  <= '0;
            template_second_reg <= '0;
            coeff_first_reg     <= '0;
            coeff_second_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            case (bgtm_reg_t'(cfg.index))
                REG_IMAGE_WIDTH:     width_last_reg      <= width_eff - 1'b1;
                REG_TEMPLATE_FIRST:  template_first_reg  <= cfg.data;
                REG_TEMPLATE_SECOND: template_second_reg <= cfg.data;
                REG_COEFF_FIRST:     coeff_first_reg     <= cfg.data[COEFF_W-1:0];
                REG_COEFF_SECOND:    coeff_second_reg    <= cfg.data[COEFF_W-1:0];
                default:             ;
            endcase
        end
    end

    bgtm_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (pix_accept),
        .magnitude   (pix.magnitude),
        .frame_start (pix.frame_start),
        .width_last  (width_last_reg),
        .win_valid   (win_valid),
        .win         (win),
        .win_flags   (win_flags)
    );

    bgtm_score u_score (
        .clk             (clk),
        .rst_n           (rst_n),
        .win_valid       (win_valid),
        .win             (win),
        .win_flags       (win_flags),
        .template_first  (template_first_reg),
        .template_second (template_second_reg),
        .coeff_first     (coeff_first_reg),
        .coeff_second    (coeff_second_reg),
        .res_valid       (score_valid),
        .res             (score_res)
    );

    bgtm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (pix_accept),
        .credit_ok (credit_ok),
        .push      (score_valid),
        .push_data (score_res),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (head)
    );

    assign res.score       = $signed(head.score);
    assign res.window_full = head.window_full;
    assign res.row_end     = head.row_end;

endmodule

### hw/rtl/bgtm_ram.sv
// generic single write port ram with registered read
module bgtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bgtm_window.sv
// position counters, row shift words and column store read-modify-write
module bgtm_window #(
    parameter int MAX_WIDTH = bgtm_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int CMP_W = (COL_W + 1 > bgtm_pkg::IMG_W_BITS) ? COL_W + 1
                                                               : bgtm_pkg::IMG_W_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           magnitude,
    input  logic                 frame_start,
    input  logic [CMP_W-1:0]     width_last,
    output logic                 win_valid,
    output bgtm_pkg::bgtm_win_t  win,
    output bgtm_pkg::bgtm_flags_t win_flags
);
    import bgtm_pkg::*;

    localparam int ENTRY_W = PLANES * WORD_W;

    logic [COL_W-1:0]              col_reg, col_next, col_cur;
    logic [ROWS_W-1:0]             rows_reg, rows_next, rows_cur;
    logic [PLANES-1:0][7:0]        rw_reg, rw_next, rw_cur, rw_new;
    bgtm_flags_t                   flags_cur;

    logic                          p0_valid_reg;
    logic [COL_W-1:0]              p0_col_reg;
    logic                          p0_above_reg;
    logic [PLANES-1:0][7:0]        p0_row_reg;
    bgtm_flags_t                   p0_flags_reg;

    logic [ENTRY_W-1:0]            ram_rdata;
    bgtm_win_t                     win_next;

    logic                          win_valid_reg;
    bgtm_win_t                     win_reg;
    bgtm_flags_t                   win_flags_reg;

    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        rows_cur = frame_start ? '0 : rows_reg;
        rw_cur   = frame_start ? '0 : rw_reg;
        for (int p = 0; p < PLANES; p++)
        begin
            rw_new[p] = {rw_cur[p][6:0], magnitude[PLANE_LSB + p]};
        end
        flags_cur.last = {{(CMP_W - COL_W){1'b0}}, col_cur} >= width_last;
        flags_cur.full = (rows_cur == ROWS_MAX) && (col_cur >= COL_W'(WIN_SIZE - 1));
        if (flags_cur.last)
        begin
            col_next  = '0;
            rows_next = (rows_cur == ROWS_MAX) ? rows_cur : rows_cur + 1'b1;
            rw_next   = '0;
        end
        else
        begin
            col_next  = col_cur + 1'b1;
            rows_next = rows_cur;
            rw_next   = rw_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            rows_reg      <= '0;
            rw_reg        <= '0;
            p0_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg  <= col_next;
                rows_reg <= rows_next;
                rw_reg   <= rw_next;
            end
            p0_valid_reg  <= accept;
            win_valid_reg <= p0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_col_reg   <= col_cur;
            p0_above_reg <= rows_cur != '0;
            p0_row_reg   <= rw_new;
            p0_flags_reg <= flags_cur;
        end
        if (p0_valid_reg)
        begin
            win_reg       <= win_next;
            win_flags_reg <= p0_flags_reg;
        end
    end

    // consecutive beats never share a column unless the later one starts a
    // frame, and then the entry read is masked, so no forwarding path is needed
    bgtm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_col_store (
        .clk   (clk),
        .we    (p0_valid_reg),
        .waddr (p0_col_reg),
        .wdata (win_next),
        .re    (accept),
        .raddr (col_cur),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            win_next[p] = {p0_above_reg ? ram_rdata[p*WORD_W +: WORD_W-8] : {(WORD_W-8){1'b0}},
                           p0_row_reg[p]};
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;
    assign win_flags = win_flags_reg;

endmodule

### hw/rtl/bgtm_score.sv
// pipelined popcount, plane weighting, coefficient multiply and sum of the two template terms
module bgtm_score (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         win_valid,
    input  bgtm_pkg::bgtm_win_t          win,
    input  bgtm_pkg::bgtm_flags_t        win_flags,
    input  logic [bgtm_pkg::WORD_W-1:0]  template_first,
    input  logic [bgtm_pkg::WORD_W-1:0]  template_second,
    input  logic signed [bgtm_pkg::COEFF_W-1:0] coeff_first,
    input  logic signed [bgtm_pkg::COEFF_W-1:0] coeff_second,
    output logic                         res_valid,
    output bgtm_pkg::bgtm_result_t       res
);
    import bgtm_pkg::*;

    function automatic logic signed [SUM_W-1:0] plane_total(input bgtm_cnt_t a,
                                                            input bgtm_cnt_t w);
        logic signed [CNT_W+1:0] d;
        logic signed [SUM_W-1:0] t;
        t = '0;
        for (int p = 0; p < PLANES; p++)
        begin
            d = $signed({1'b0, a[p], 1'b0}) - $signed({2'b00, w[p]});
            t = t + (SUM_W'(d) <<< p);
        end
        return t;
    endfunction

    logic                      a_valid_reg;
    bgtm_cnt_t                 a_first_reg, a_second_reg, a_win_reg;
    bgtm_flags_t               a_flags_reg;

    logic                      b_valid_reg;
    logic signed [SUM_W-1:0]   b_first_reg, b_second_reg;
    bgtm_flags_t               b_flags_reg;

    logic                      c_valid_reg;
    logic signed [SCORE_W-1:0] c_first_reg, c_second_reg;
    bgtm_flags_t               c_flags_reg;

    logic                      d_valid_reg;
    bgtm_result_t              d_res_reg;

    bgtm_cnt_t                 a_first_next, a_second_next, a_win_next;

    always_comb
    begin
        for (int p = 0; p < PLANES; p++)
        begin
            a_first_next[p]  = count_ones64(template_first & win[p]);
            a_second_next[p] = count_ones64(template_second & win[p]);
            a_win_next[p]    = count_ones64(win[p]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= win_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid)
        begin
            a_first_reg  <= a_first_next;
            a_second_reg <= a_second_next;
            a_win_reg    <= a_win_next;
            a_flags_reg  <= win_flags;
        end
        if (a_valid_reg)
        begin
            b_first_reg  <= plane_total(a_first_reg, a_win_reg);
            b_second_reg <= plane_total(a_second_reg, a_win_reg);
            b_flags_reg  <= a_flags_reg;
        end
        if (b_valid_reg)
        begin
            c_first_reg  <= SCORE_W'(coeff_first) * SCORE_W'(b_first_reg);
            c_second_reg <= SCORE_W'(coeff_second) * SCORE_W'(b_second_reg);
            c_flags_reg  <= b_flags_reg;
        end
        if (c_valid_reg)
        begin
            d_res_reg.score       <= c_first_reg + c_second_reg;
            d_res_reg.window_full <= c_flags_reg.full;
            d_res_reg.row_end     <= c_flags_reg.last;
        end
    end

    assign res_valid = d_valid_reg;
    assign res       = d_res_reg;

endmodule

### hw/rtl/bgtm_outq.sv
// result queue with credit count that gates the pixel input
module bgtm_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_accept,
    output logic                   credit_ok,
    input  logic                   push,
    input  bgtm_pkg::bgtm_result_t push_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bgtm_pkg::bgtm_result_t out_data
);
    import bgtm_pkg::*;

    bgtm_result_t            q_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0]   fill_reg, fill_next;
    logic [OUTQ_CNT_W-1:0]   owed_reg, owed_next;
    logic                    pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = fill_reg != '0;
    assign out_data  = q_reg[rd_ptr_reg];
    // beats in flight plus beats queued never exceed the queue depth
    assign credit_ok = owed_reg < OUTQ_CNT_W'(OUTQ_DEPTH);

    always_comb
    begin
        fill_next = fill_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
        owed_next = owed_reg + OUTQ_CNT_W'(in_accept) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            owed_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            owed_reg <= owed_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/bgtm_checker.sv
// port level checks for the template match block, bound to the top level
module bgtm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pix_valid,
    input logic                          pix_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [bgtm_pkg::SCORE_W-1:0]  res_score,
    input logic                          res_window_full,
    input logic                          res_row_end
);
    import bgtm_pkg::*;

    logic [7:0] owed_reg;

    // pixel beats whose results have not yet left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else
        begin
            owed_reg <= owed_reg + 8'(pix_valid && pix_ready) - 8'(res_valid && res_ready);
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_score, res_window_full, res_row_end}))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> owed_reg != 8'd0)
        else $error("result offered with no pixel outstanding");

    a_stall_owed: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> owed_reg != 8'd0)
        else $error("pixel input stalled with nothing owed");

endmodule

bind binary_gradient_template_match bgtm_checker u_bgtm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pix_valid       (pix.valid),
    .pix_ready       (pix.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_score       (res.score),
    .res_window_full (res.window_full),
    .res_row_end     (res.row_end)
);

### tb/tb.sv
// testbench for the template match block: directed and random pixel streams, scores predicted
`timescale 1ns / 1ps

module tb;
    import bgtm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int PIPE_LATENCY  = 6;
    localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
    localparam int HOLD_CYCLES   = 120;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 4;
    localparam int RANDOM_ITEMS  = 240;
    localparam int MAX_GAP       = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [7:0] EDGE_MAGS [8] = '{8'hFF, 8'h00, 8'h10, 8'h20,
                                             8'h40, 8'h80, 8'h0F, 8'hF0};

    logic clk = 1'b0;
    logic rst_n;

    bgtm_pix_if   pix_ch ();
    bgtm_cfg_if   cfg_ch ();
    bgtm_score_if res_ch ();

    binary_gradient_template_match #(
        .MAX_WIDTH (MAX_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_ch.sink),
        .cfg   (cfg_ch.sink),
        .res   (res_ch.source)
    );

    // register copies and window state of the scoring model
    logic [IMG_W_BITS-1:0]     width_reg;
    logic [WORD_W-1:0]         tmpl_a;
    logic [WORD_W-1:0]         tmpl_b;
    logic signed [COEFF_W-1:0] coeff_a;
    logic signed [COEFF_W-1:0] coeff_b;
    int                        col_pos;
    int                        rows_done;
    logic [PLANES-1:0][7:0]    row_bits;
    bgtm_win_t                 col_store [MAX_W];

    bgtm_result_t pending_scores [$];

    int     n_pixels;
    int     n_scores;
    int     n_full;
    int     n_writes;
    int     n_errors;
    longint cycles;

    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    bit hold_active;
    bit frame_due;

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d scores still owed", cycles,
                     pending_scores.size());
            $display("tb: errors");
            $finish;
        end
    end

    function automatic int eff_width(input logic [IMG_W_BITS-1:0] w);
        if (w < MIN_WIDTH)
            return MIN_WIDTH;
        if (w > MAX_W)
            return MAX_W;
        return int'(w);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // per plane: twice the agreeing ones minus the window ones, weighted by plane
    function automatic longint template_agreement(input logic [WORD_W-1:0] tmpl,
                                                  input bgtm_win_t win);
        longint total;
        total = 0;
        for (int p = 0; p < PLANES; p++)
        begin
            total += longint'(2 * $countones(tmpl & win[p]) - $countones(win[p]))
                     * (longint'(1) << p);
        end
        return total;
    endfunction

    task automatic predict_score(input logic [7:0] mag, input logic fs);
        int           col;
        bgtm_win_t    above;
        bgtm_win_t    win;
        bgtm_result_t r;
        longint       s;
        if (fs)
        begin
            col_pos   = 0;
            rows_done = 0;
            row_bits  = '0;
        end
        col   = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        above = (rows_done == 0) ? '0 : col_store[col];
        for (int p = 0; p < PLANES; p++)
        begin
            row_bits[p] = {row_bits[p][6:0], mag[PLANE_LSB + p]};
            win[p]      = {above[p][WORD_W-WIN_SIZE-1:0], row_bits[p]};
        end
        col_store[col] = win;
        s = longint'(coeff_a) * template_agreement(tmpl_a, win)
          + longint'(coeff_b) * template_agreement(tmpl_b, win);
        r.score       = s[SCORE_W-1:0];
        r.window_full = (rows_done >= WIN_SIZE - 1) && (col_pos >= WIN_SIZE - 1);
        r.row_end     = col_pos >= eff_width(width_reg) - 1;
        pending_scores.insert(pending_scores.size(), r);
        if (r.row_end)
        begin
            col_pos  = 0;
            row_bits = '0;
            if (rows_done < WIN_SIZE - 1)
                rows_done++;
        end
        else
        begin
            col_pos++;
        end
    endtask

    task automatic send_pixel(input logic [7:0] mag, input logic fs);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        // a wider image must start afresh, the column store past the old width is stale
        if (frame_due)
            fs = 1'b1;
        repeat (gap)
        begin
            @(negedge clk);
            pix_ch.valid <= 1'b0;
        end
        @(negedge clk);
        pix_ch.valid       <= 1'b1;
        pix_ch.magnitude   <= mag;
        pix_ch.frame_start <= fs;
        do @(posedge clk); while (!pix_ch.ready);
        predict_score(mag, fs);
        if (fs)
            frame_due = 1'b0;
        n_pixels++;
    endtask

    task automatic send_random_pixels(input int count, input bit new_frame);
        for (int i = 0; i < count; i++)
        begin
            send_pixel(8'($urandom_range(0, 255)), new_frame && i == 0);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            REG_IMAGE_WIDTH:
            begin
                if (eff_width(data[IMG_W_BITS-1:0]) > eff_width(width_reg))
                    frame_due = 1'b1;
                width_reg = data[IMG_W_BITS-1:0];
            end
            REG_TEMPLATE_FIRST:  tmpl_a  = data;
            REG_TEMPLATE_SECOND: tmpl_b  = data;
            REG_COEFF_FIRST:     coeff_a = data[COEFF_W-1:0];
            REG_COEFF_SECOND:    coeff_b = data[COEFF_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // width in the low bits, junk above that the block must drop
    task automatic write_width(input logic [IMG_W_BITS-1:0] w);
        logic [CFG_DATA_W-1:0] data;
        data = rand64();
        data[IMG_W_BITS-1:0] = w;
        write_reg(REG_IMAGE_WIDTH, data);
    endtask

    task automatic write_coeff(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [COEFF_W-1:0] c);
        logic [CFG_DATA_W-1:0] data;
        data = rand64();
        data[COEFF_W-1:0] = c;
        write_reg(idx, data);
    endtask

    task automatic check_score();
        bgtm_result_t exp_r;
        n_scores++;
        if (res_ch.window_full)
            n_full++;
        if (pending_scores.size() == 0)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("score beat with nothing owed: score %0d full %b end %b",
                         res_ch.score, res_ch.window_full, res_ch.row_end);
            return;
        end
        exp_r = pending_scores.pop_front();
        if (res_ch.score !== exp_r.score || res_ch.window_full !== exp_r.window_full
            || res_ch.row_end !== exp_r.row_end)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("score beat %0d: expected %0d/%b/%b got %0d/%b/%b", n_scores,
                         $signed(exp_r.score), exp_r.window_full, exp_r.row_end,
                         res_ch.score, res_ch.window_full, res_ch.row_end);
        end
    endtask

    initial
    begin : score_sink
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            while (stall > 0 || hold_active)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
                if (stall > 0)
                    stall--;
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            check_score();
        end
    end

    // long output hold so the result queue fills and the pixel input backs up
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            wait (hold_req);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
            hold_req    = 1'b0;
        end
    end

    task automatic test_reset_state();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_random_pixels(12, 1'b0);
        send_random_pixels(4, 1'b1);
        wait_idle();
    endtask

    task automatic test_extreme_settings();
        write_width(11'd3);
        write_reg(REG_TEMPLATE_FIRST, '1);
        write_reg(REG_TEMPLATE_SECOND, '0);
        write_coeff(REG_COEFF_FIRST, 32'h7FFF_FFFF);
        write_coeff(REG_COEFF_SECOND, 32'h8000_0000);
        for (int i = 0; i < WIN_SIZE * WIN_SIZE; i++)
            send_pixel(8'hFF, i == 0);
        for (int i = 0; i < WIN_SIZE; i++)
            send_pixel(EDGE_MAGS[i], 1'b0);
        wait_idle();
        // flip signs for the most negative score
        write_reg(REG_TEMPLATE_FIRST, '0);
        write_reg(REG_TEMPLATE_SECOND, '1);
        for (int i = 0; i < WIN_SIZE * WIN_SIZE; i++)
            send_pixel(8'hFF, i == 0);
        wait_idle();
        write_reg(REG_SPARE_LO, rand64());
        write_reg(REG_SPARE_HI, rand64());
        send_random_pixels(10, 1'b0);
        wait_idle();
    endtask

    task automatic test_width_changes();
        write_reg(REG_TEMPLATE_FIRST, rand64());
        write_coeff(REG_COEFF_FIRST, $urandom);
        write_width(11'd16);
        send_random_pixels(42, 1'b1);
        wait_idle();
        // column already past the new last column, so the next pixel closes the row
        write_width(11'd8);
        send_random_pixels(20, 1'b0);
        wait_idle();
        write_width(11'd0);
        send_random_pixels(8, 1'b0);
        wait_idle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_width(11'h7FF);
        send_random_pixels(MAX_W + WIN_SIZE, 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_width(11'd12);
        write_reg(REG_TEMPLATE_SECOND, rand64());
        write_coeff(REG_COEFF_SECOND, $urandom);
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 1'b1;
        send_random_pixels(48, 1'b1);
        wait_idle();
        rx_idle = 1'b1;
        send_random_pixels(24, 1'b0);
        wait_idle();
    endtask

    task automatic randomize_settings();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            write_width(11'($urandom_range(MIN_WIDTH, 40)));
        else if (pick < 17)
            write_width(11'($urandom_range(0, MIN_WIDTH - 1)));
        else
            write_width(11'($urandom_range(41, 160)));
        write_reg(REG_TEMPLATE_FIRST, rand64());
        write_reg(REG_TEMPLATE_SECOND, rand64());
        write_coeff(REG_COEFF_FIRST, $urandom);
        write_coeff(REG_COEFF_SECOND, $urandom);
    endtask

    // image frames with random content, cut off by the pixel budget, plus the odd stray frame start
    task automatic test_random_frames();
        int budget;
        int frame_len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            randomize_settings();
            tx_idle = $urandom_range(0, 2) != 0;
            rx_idle = $urandom_range(0, 2) != 0;
            if (phase == RANDOM_PHASES / 2)
                hold_req = 1'b1;
            budget = RANDOM_ITEMS / RANDOM_PHASES;
            while (budget > 0)
            begin
                frame_len = eff_width(width_reg) * $urandom_range(WIN_SIZE, WIN_SIZE + 3);
                for (int px = 0; px < frame_len && budget > 0; px++)
                begin
                    send_pixel(8'($urandom_range(0, 255)),
                               px == 0 || $urandom_range(0, 63) == 0);
                    budget--;
                end
            end
        end
        wait_idle();
    endtask

    initial
    begin
        width_reg          = IMG_W_BITS'(IMAGE_WIDTH_RST);
        tmpl_a             = '0;
        tmpl_b             = '0;
        coeff_a            = '0;
        coeff_b            = '0;
        col_pos            = 0;
        rows_done          = 0;
        row_bits           = '0;
        n_pixels           = 0;
        n_scores           = 0;
        n_full             = 0;
        n_writes           = 0;
        n_errors           = 0;
        cycles             = 0;
        tx_idle            = 1'b0;
        rx_idle            = 1'b0;
        hold_req           = 1'b0;
        frame_due          = 1'b0;
        pix_ch.valid       = 1'b0;
        pix_ch.magnitude   = '0;
        pix_ch.frame_start = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        rst_n              = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_extreme_settings();
        test_width_changes();
        test_backpressure();
        test_random_frames();

        $display("run: %0d pixels, %0d register writes, %0d scores checked",
                 n_pixels, n_writes, n_scores);
        $display("run: %0d scores over full windows, widths 8 to 1024, %0d failures",
                 n_full, n_errors);
        if (n_errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

### binary_gradient_template_match.f
hw/rtl/bgtm_pkg.sv
hw/rtl/bgtm_if.sv
hw/rtl/bgtm_ram.sv
hw/rtl/bgtm_window.sv
hw/rtl/bgtm_score.sv
hw/rtl/bgtm_outq.sv
hw/rtl/binary_gradient_template_match.sv
hw/rtl/bgtm_checker.sv
tb/tb.sv
